// File: src/reverse_nibble_name_to_ipv6_assert.svh
// Assertion macros used by the checker of this block.
// Each macro expands to one labeled concurrent assertion on i_clk,
// disabled while i_rst_n is low.
`ifndef REVERSE_NIBBLE_NAME_TO_IPV6_ASSERT_SVH
`define REVERSE_NIBBLE_NAME_TO_IPV6_ASSERT_SVH

// Same-cycle implication
`define RNN_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define RNN_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: src/rnn_pkg.sv
// ----------------------------------------------------------------------------
// rnn_pkg
// Shared types, constants and character helpers for the reverse nibble name
// to IPv6 address decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rnn_pkg;

    localparam int CharW    = 8;
    localparam int PosW     = 7;
    localparam int AddrW    = 128;
    localparam int HalfW    = AddrW / 2;
    localparam int NibIdxW  = $clog2(AddrW / 4);

    // Name layout: 32 digits each followed by a dot, then "ip6.arpa."
    localparam int DigitChars = 64;
    localparam int TailLen    = 9;
    localparam int TailIdxW   = $clog2(TailLen);
    localparam int PosMax     = (1 << PosW) - 1;
    // Last byte must sit on the final 'a' or on the optional trailing dot
    localparam int EndShort   = DigitChars + TailLen - 2;
    localparam int EndLong    = DigitChars + TailLen - 1;

    localparam logic [CharW-1:0] ChDot   = 8'h2E;
    localparam logic [CharW-1:0] ChZero  = 8'h30;
    localparam logic [CharW-1:0] ChNine  = 8'h39;
    localparam logic [CharW-1:0] ChLoA   = 8'h61;
    localparam logic [CharW-1:0] ChLoF   = 8'h66;
    localparam logic [CharW-1:0] ChUpA   = 8'h41;
    localparam logic [CharW-1:0] ChUpF   = 8'h46;
    localparam logic [CharW-1:0] ChUpZ   = 8'h5A;
    localparam logic [CharW-1:0] CaseOfs = 8'h20;

    // Per-character verdict from the checker to the accumulator
    typedef struct packed {
        logic               err;
        logic               nib_we;
        logic [NibIdxW-1:0] nib_idx;
        logic [3:0]         nib_val;
    } t_step;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_hex;

    function automatic t_hex hex_decode(input logic [CharW-1:0] c);
        t_hex h;
        h.ok  = 1'b1;
        h.val = 4'd0;
        if (c >= ChZero && c <= ChNine) begin
            h.val = 4'(c - ChZero);
        end else if (c >= ChLoA && c <= ChLoF) begin
            h.val = 4'(c - ChLoA) + 4'd10;
        end else if (c >= ChUpA && c <= ChUpF) begin
            h.val = 4'(c - ChUpA) + 4'd10;
        end else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

    function automatic logic [CharW-1:0] fold_case(input logic [CharW-1:0] c);
        if (c >= ChUpA && c <= ChUpZ) begin
            return c + CaseOfs;
        end
        return c;
    endfunction

    // Expected text of "ip6.arpa." by offset
    function automatic logic [CharW-1:0] tail_char(input logic [TailIdxW-1:0] idx);
        logic [CharW-1:0] c;
        case (idx)
            4'd0:    c = 8'h69; // i
            4'd1:    c = 8'h70; // p
            4'd2:    c = 8'h36; // 6
            4'd3:    c = ChDot;
            4'd4:    c = 8'h61; // a
            4'd5:    c = 8'h72; // r
            4'd6:    c = 8'h70; // p
            4'd7:    c = 8'h61; // a
            4'd8:    c = ChDot;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// File: src/rnn_char_check.sv
// ----------------------------------------------------------------------------
// rnn_char_check
// Checks one character against what its position in the name requires and
// extracts the nibble from digit positions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rnn_char_check (
    input  wire logic [rnn_pkg::CharW-1:0] i_char,
    input  wire logic [rnn_pkg::PosW-1:0]  i_pos,
    output rnn_pkg::t_step                 o_step
);
    import rnn_pkg::*;

    t_hex                h;
    logic [TailIdxW-1:0] tail_idx;
    logic [PosW-1:0]     tail_ofs;

    assign h        = hex_decode(i_char);
    assign tail_ofs = i_pos - PosW'(DigitChars);
    assign tail_idx = tail_ofs[TailIdxW-1:0];

    // Position-dependent match
    always_comb begin
        o_step         = '0;
        o_step.nib_idx = i_pos[NibIdxW:1];
        o_step.nib_val = h.val;
        if (i_pos < PosW'(DigitChars)) begin
            if (!i_pos[0]) begin
                o_step.err    = !h.ok;
                o_step.nib_we = h.ok;
            end else begin
                o_step.err = (i_char != ChDot);
            end
        end else if (i_pos < PosW'(DigitChars + TailLen)) begin
            o_step.err = (fold_case(i_char) != tail_char(tail_idx));
        end else begin
            o_step.err = 1'b1;
        end
    end

endmodule

`default_nettype wire

// File: src/reverse_nibble_name_to_ipv6.sv
// A request's last character reaches the result via the input register, then the result register.
// Throughput: 1 character per cycle; input register and result register
// are each a single stage, and a held result only blocks a last character.
// Reset (synchronous, active low) clears the position, error flag, address
// accumulator and both valid bits.
// ----------------------------------------------------------------------------
// reverse_nibble_name_to_ipv6
// Decodes an ip6.arpa reverse nibble name, one character per request, into
// a validity flag and a 128-bit address.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module reverse_nibble_name_to_ipv6 (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output      logic                      o_in_stall,
    input  wire logic [rnn_pkg::CharW-1:0] i_char_in,
    input  wire logic                      i_last,
    output      logic                      o_out_valid,
    input  wire logic                      i_out_stall,
    output      logic                      o_valid_res,
    output      logic [rnn_pkg::HalfW-1:0] o_addr_high,
    output      logic [rnn_pkg::HalfW-1:0] o_addr_low
);
    import rnn_pkg::*;

    // Input register
    logic             r_in_valid;
    logic [CharW-1:0] r_char;
    logic             r_last;

    // Name state
    logic [PosW-1:0]  r_pos, n_pos;
    logic             r_err, n_err;
    logic [AddrW-1:0] r_addr, n_addr;

    // Result register
    logic             r_out_valid;
    logic             r_valid_res;
    logic [AddrW-1:0] r_res_addr;

    t_step            step;
    logic             advance;
    logic             ok;

    rnn_char_check u_check (
        .i_char (r_char),
        .i_pos  (r_pos),
        .o_step (step)
    );

    // A last character needs a free result slot
    assign advance    = r_in_valid && (!r_last || !r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_char <= i_char_in;
            r_last <= i_last;
        end
    end

    // Next name state
    always_comb begin
        n_err  = r_err | step.err;
        n_addr = r_addr;
        if (step.nib_we) begin
            n_addr[{step.nib_idx, 2'b00} +: 4] = step.nib_val;
        end
        n_pos = (r_pos == PosW'(PosMax)) ? r_pos : r_pos + PosW'(1);
    end

    assign ok = !n_err && (r_pos == PosW'(EndShort) || r_pos == PosW'(EndLong));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_err  <= 1'b0;
            r_addr <= '0;
        end else if (advance) begin
            if (r_last) begin
                r_pos  <= '0;
                r_err  <= 1'b0;
                r_addr <= '0;
            end else begin
                r_pos  <= n_pos;
                r_err  <= n_err;
                r_addr <= n_addr;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_last) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_last) begin
            r_valid_res <= ok;
            r_res_addr  <= ok ? n_addr : '0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_valid_res = r_valid_res;
    assign o_addr_high = r_res_addr[AddrW-1:HalfW];
    assign o_addr_low  = r_res_addr[HalfW-1:0];

endmodule

`default_nettype wire

// File: src/rnn_checker.sv
// ----------------------------------------------------------------------------
// rnn_checker
// Port-level checks of the reverse nibble name decoder, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "reverse_nibble_name_to_ipv6_assert.svh"

module rnn_checker (
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      o_in_stall,
    input wire logic                      o_out_valid,
    input wire logic                      i_out_stall,
    input wire logic                      o_valid_res,
    input wire logic [rnn_pkg::HalfW-1:0] o_addr_high,
    input wire logic [rnn_pkg::HalfW-1:0] o_addr_low
);
    import rnn_pkg::*;

    logic             held;
    logic             rejected;
    logic             addr_zero;
    logic [2*HalfW:0] res_bits;

    assign held      = o_out_valid && i_out_stall;
    assign rejected  = o_out_valid && !o_valid_res;
    assign addr_zero = (o_addr_high == '0) && (o_addr_low == '0);
    assign res_bits  = {o_valid_res, o_addr_high, o_addr_low};

    // Held result stays put
    `RNN_ASSERT_NEXT(a_out_hold, held, o_out_valid && $stable(res_bits), "held result changed")

    // Rejected names carry a zero address
    `RNN_ASSERT_NOW(a_invalid_zero, rejected, addr_zero, "nonzero address on invalid")

    // Input never backs up while the result slot is empty
    `RNN_ASSERT_NOW(a_no_idle_stall, !o_out_valid, !o_in_stall, "stall with empty result slot")

    // Stall only comes from a stalled result
    `RNN_ASSERT_NOW(a_stall_cause, o_in_stall, held, "input stall without output stall")

endmodule

bind reverse_nibble_name_to_ipv6 rnn_checker u_rnn_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_valid_res (o_valid_res),
    .o_addr_high (o_addr_high),
    .o_addr_low  (o_addr_low)
);

`default_nettype wire
